/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue: field widths,
// result status codes, the stored slot layout and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int PRIO_W   = 8;
  localparam int ID_W     = 17;
  localparam int BYTES_W  = 32;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 7;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Read address choices of the slot memory.
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_TAIL_PREV,
    RD_PTR_PREV2
  } rd_sel_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [ID_W-1:0]     id;
    logic [BYTES_W-1:0]  bytes;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  typedef struct packed {
    logic    take;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    shift;
    logic    insert;
    logic    pop;
    logic    res_load;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic shift_needed;
    logic last_shift;
  } stat_t;

endpackage

/* rtl/spq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Circular slot memory with head pointer and fill count, the scan pointer
// used while an entry is inserted, the held input word and the result
// register.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spq_pkg::cmd_t                 cmd,
  output spq_pkg::stat_t                stat,
  input  logic [spq_pkg::PRIO_W-1:0]    entry_priority,
  input  logic [spq_pkg::ID_W-1:0]      chunk_id,
  input  logic [spq_pkg::BYTES_W-1:0]   byte_count,
  input  logic [spq_pkg::HANDLE_W-1:0]  buffer_handle,
  output logic [spq_pkg::STATUS_W-1:0]  status,
  output logic [spq_pkg::PRIO_W-1:0]    out_priority,
  output logic [spq_pkg::ID_W-1:0]      out_chunk_id,
  output logic [spq_pkg::BYTES_W-1:0]   out_byte_count,
  output logic [spq_pkg::HANDLE_W-1:0]  out_buffer_handle,
  output logic [spq_pkg::HELD_W-1:0]    entries_held
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::slot_t mem [QUEUE_DEPTH];
  spq_pkg::slot_t rdata;
  spq_pkg::slot_t item;
  spq_pkg::slot_t wr_data;

  logic [AW-1:0] head;
  logic [AW-1:0] ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] left;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] ptr_dec;
  logic [AW-1:0] rd_addr;
  logic [31:0]   held_wide;

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == '0) begin
      r = AW'(QUEUE_DEPTH - 1);
    end else begin
      r = a - AW'(1);
    end
    return r;
  endfunction

  always_comb begin
    tail_sum = (CW+1)'(head) + (CW+1)'(count);
    if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CW+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[AW-1:0];
  end

  assign ptr_dec = wrap_dec(ptr);

  always_comb begin
    case (cmd.rd_sel)
      spq_pkg::RD_HEAD:      rd_addr = head;
      spq_pkg::RD_TAIL_PREV: rd_addr = wrap_dec(tail);
      spq_pkg::RD_PTR_PREV2: rd_addr = wrap_dec(ptr_dec);
      default:               rd_addr = head;
    endcase
  end

  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  assign held_wide = 32'(count_next);
  assign wr_data   = cmd.shift ? rdata : item;

  assign stat.empty        = (count == '0);
  assign stat.full         = (count == CW'(QUEUE_DEPTH));
  assign stat.shift_needed = (rdata.prio > item.prio);
  assign stat.last_shift   = (left == CW'(1));

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.shift || cmd.insert) begin
      mem[ptr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (cmd.pop) begin
        head <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item.prio   <= entry_priority;
      item.id     <= chunk_id;
      item.bytes  <= byte_count;
      item.handle <= buffer_handle;
      ptr         <= tail;
      left        <= count;
    end else if (cmd.shift) begin
      ptr  <= ptr_dec;
      left <= left - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status       <= cmd.res_status;
      entries_held <= held_wide[spq_pkg::HELD_W-1:0];
      if (cmd.res_status == spq_pkg::ST_POPPED) begin
        out_priority      <= rdata.prio;
        out_chunk_id      <= rdata.id;
        out_byte_count    <= rdata.bytes;
        out_buffer_handle <= rdata.handle;
      end else begin
        out_priority      <= '0;
        out_chunk_id      <= '0;
        out_byte_count    <= '0;
        out_buffer_handle <= '0;
      end
    end
  end

endmodule

/* rtl/spq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the stable priority queue: takes one word at a time, walks
// the insertion scan from the tail and loads the result register.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_mode,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    POP_RD,
    SCAN,
    PLACE,
    REPORT
  } state_t;

  state_t           state;
  state_t           state_next;
  spq_pkg::status_t rep_status;
  spq_pkg::status_t rep_status_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != IDLE);

  always_comb begin
    cmd             = '0;
    cmd.rd_sel      = spq_pkg::RD_HEAD;
    cmd.res_status  = spq_pkg::ST_PUSHED;
    state_next      = state;
    rep_status_next = rep_status;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_mode == spq_pkg::MODE_POP) begin
            if (stat.empty) begin
              rep_status_next = spq_pkg::ST_EMPTY;
              state_next      = REPORT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = spq_pkg::RD_HEAD;
              state_next = POP_RD;
            end
          end else if (stat.full) begin
            rep_status_next = spq_pkg::ST_FULL;
            state_next      = REPORT;
          end else if (stat.empty) begin
            state_next = PLACE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = spq_pkg::RD_TAIL_PREV;
            state_next = SCAN;
          end
        end
      end
      POP_RD: begin
        if (out_free) begin
          cmd.pop        = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = spq_pkg::ST_POPPED;
          state_next     = IDLE;
        end
      end
      SCAN: begin
        // Entries with a higher priority value move back one slot.
        if (stat.shift_needed) begin
          cmd.shift  = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = spq_pkg::RD_PTR_PREV2;
          if (stat.last_shift) begin
            state_next = PLACE;
          end
        end else begin
          state_next = PLACE;
        end
      end
      PLACE: begin
        if (out_free) begin
          cmd.insert     = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = spq_pkg::ST_PUSHED;
          state_next     = IDLE;
        end
      end
      REPORT: begin
        if (out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = rep_status;
          state_next     = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      rep_status <= spq_pkg::ST_PUSHED;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rep_status <= rep_status_next;
      out_valid  <= cmd.res_load || (out_valid && out_stall);
    end
  end

endmodule

/* rtl/stable_priority_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded min-priority queue kept in sorted order. Equal priorities leave
// in arrival order.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  mode, entry_priority, chunk_id,
//                                          byte_count, buffer_handle
// out      output     out_valid / out_stall status, out_priority, out_chunk_id,
//                                          out_byte_count, out_buffer_handle,
//                                          entries_held
//
// One word is worked on at a time. A pop reads the head slot and then
// loads the result. A push first moves back, one slot per cycle, every
// stored entry with a higher priority value, through the single write port
// of the slot memory, and then writes the new entry. A pop on an empty
// queue and a push into a full one go straight to the result register.
// Reset (rst, synchronous) empties the queue at once; slot contents are
// not cleared, since the contents of unoccupied slots are never used.
// A stalled result stays in the output register while the next word is
// accepted; that word finishes once the register has been emptied.
//
// The entries sit in a circular memory of QUEUE_DEPTH slots, addressed
// from a head pointer, so a pop only advances the head. A push scans from
// the tail toward the head, moving each entry whose priority value is
// greater than the new one back by one slot, and writes the new entry in
// the gap that is left. The comparison against an equal priority stops the
// scan, which keeps the order of equal priorities first in, first out.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [spq_pkg::PRIO_W-1:0]    entry_priority,
  input  logic [spq_pkg::ID_W-1:0]      chunk_id,
  input  logic [spq_pkg::BYTES_W-1:0]   byte_count,
  input  logic [spq_pkg::HANDLE_W-1:0]  buffer_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spq_pkg::STATUS_W-1:0]  status,
  output logic [spq_pkg::PRIO_W-1:0]    out_priority,
  output logic [spq_pkg::ID_W-1:0]      out_chunk_id,
  output logic [spq_pkg::BYTES_W-1:0]   out_byte_count,
  output logic [spq_pkg::HANDLE_W-1:0]  out_buffer_handle,
  output logic [spq_pkg::HELD_W-1:0]    entries_held
);

  // Commands from the sequencer and the status it steers by.
  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .entry_priority    (entry_priority),
    .chunk_id          (chunk_id),
    .byte_count        (byte_count),
    .buffer_handle     (buffer_handle),
    .status            (status),
    .out_priority      (out_priority),
    .out_chunk_id      (out_chunk_id),
    .out_byte_count    (out_byte_count),
    .out_buffer_handle (out_buffer_handle),
    .entries_held      (entries_held)
  );

endmodule
